>>> rtl/drla_pkg.sv
// ============================================================================
// Delta-rule learner package
// Shared widths, codes, control structs and state encoding.
// ============================================================================
package drla_pkg;

    localparam int NUM_CUES  = 4;
    localparam int CUE_IDX_W = (NUM_CUES > 1) ? $clog2(NUM_CUES) : 1;
    localparam int CFG_IDX_W = 3;

    localparam int CUE_W     = 16;
    localparam int W_W       = 32;
    localparam int LR_W      = 16;
    localparam int FRAC_CUE  = 12;
    localparam int TEACH_SH  = 4;
    localparam int PROD_W    = CUE_W + W_W;
    localparam int ACC_W     = PROD_W + CUE_IDX_W + 1;
    localparam int ERR_W     = W_W + 1;
    localparam int RPROD_W   = ERR_W + LR_W + 1;
    localparam int STEP_W    = RPROD_W - LR_W;

    localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
    localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};

    localparam logic [1:0] ACT_LEARN   = 2'd0;
    localparam logic [1:0] ACT_RESTORE = 2'd1;
    localparam logic [1:0] ACT_FROZEN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_BASE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_LAST     = CFG_IDX_W'(NUM_CUES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_STEP,
        ST_UPD,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic load;
        logic restore;
        logic mul_en;
        logic upd_en;
    } lane_ctrl_t;

    typedef struct packed {
        logic load;
        logic sum_en;
        logic step_en;
    } merge_ctrl_t;

endpackage

>>> rtl/drla_lane.sv
// ============================================================================
// Delta-rule learner lane
// Holds one cue weight, forms cue times weight and applies the weight update or restores the initial weight.
// ============================================================================
module drla_lane (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  drla_pkg::lane_ctrl_t                      ctrl,
    input  logic signed [drla_pkg::CUE_W-1:0]         cue,
    input  logic signed [drla_pkg::W_W-1:0]           init_weight,
    input  logic signed [drla_pkg::STEP_W-1:0]        step,
    output logic signed [drla_pkg::PROD_W-1:0]        product,
    output logic signed [drla_pkg::W_W-1:0]           weight,
    output logic signed [drla_pkg::W_W-1:0]           weight_next
);
    import drla_pkg::*;

    localparam int UPROD_W = STEP_W + CUE_W;
    localparam int DELTA_W = UPROD_W - FRAC_CUE;
    localparam int UPD_W   = DELTA_W + 1;

    logic signed [CUE_W-1:0]   cue_reg;
    logic signed [W_W-1:0]     weight_reg;
    logic signed [PROD_W-1:0]  product_reg;
    logic signed [UPROD_W-1:0] upd_prod;
    logic signed [DELTA_W-1:0] delta;
    logic signed [UPD_W-1:0]   upd_sum;
    logic [UPD_W-W_W:0]        upd_hi;
    logic signed [W_W-1:0]     upd_sat;

    assign upd_prod = step * cue_reg;
    assign delta    = upd_prod[UPROD_W-1:FRAC_CUE];
    assign upd_sum  = UPD_W'(delta) + UPD_W'(weight_reg);
    assign upd_hi   = upd_sum[UPD_W-1:W_W-1];

    always_comb
    begin
        if ((&upd_hi) || !(|upd_hi))
        begin
            upd_sat = upd_sum[W_W-1:0];
        end
        else if (upd_sum[UPD_W-1])
        begin
            upd_sat = W_MIN;
        end
        else
        begin
            upd_sat = W_MAX;
        end
    end

    always_comb
    begin
        if (ctrl.restore)
        begin
            weight_next = init_weight;
        end
        else if (ctrl.upd_en)
        begin
            weight_next = upd_sat;
        end
        else
        begin
            weight_next = weight_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
        end
        else
        begin
            weight_reg <= weight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cue_reg <= cue;
        end
        if (ctrl.mul_en)
        begin
            product_reg <= cue_reg * weight_reg;
        end
    end

    assign product = product_reg;
    assign weight  = weight_reg;

endmodule

>>> rtl/drla_merge.sv
// ============================================================================
// Delta-rule learner merge stage
// Adds the lane products into the saturated sum and forms the shared step.
// ============================================================================
module drla_merge (
    input  logic                                  clk,
    input  drla_pkg::merge_ctrl_t                 ctrl,
    input  logic signed [drla_pkg::PROD_W-1:0]    product [drla_pkg::NUM_CUES],
    input  logic signed [drla_pkg::CUE_W-1:0]     teacher,
    input  logic [drla_pkg::LR_W-1:0]             learning_rate,
    output logic signed [drla_pkg::W_W-1:0]       sum,
    output logic signed [drla_pkg::STEP_W-1:0]    step
);
    import drla_pkg::*;

    localparam int TS_W = CUE_W + TEACH_SH;

    logic signed [CUE_W-1:0]   teacher_reg;
    logic signed [W_W-1:0]     sum_reg;
    logic signed [STEP_W-1:0]  step_reg;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_sh;
    logic [ACC_W-W_W:0]        acc_hi;
    logic signed [W_W-1:0]     sum_next;
    logic signed [TS_W-1:0]    teacher_scaled;
    logic signed [ERR_W-1:0]   err;
    logic signed [LR_W:0]      rate_s;
    logic signed [RPROD_W-1:0] rate_prod;

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NUM_CUES; i++)
        begin
            acc = acc + ACC_W'(product[i]);
        end
    end

    assign acc_sh = acc >>> FRAC_CUE;
    assign acc_hi = acc_sh[ACC_W-1:W_W-1];

    always_comb
    begin
        if ((&acc_hi) || !(|acc_hi))
        begin
            sum_next = acc_sh[W_W-1:0];
        end
        else if (acc_sh[ACC_W-1])
        begin
            sum_next = W_MIN;
        end
        else
        begin
            sum_next = W_MAX;
        end
    end

    assign teacher_scaled = signed'({teacher_reg, {TEACH_SH{1'b0}}});
    assign err            = ERR_W'(teacher_scaled) - ERR_W'(sum_reg);
    assign rate_s         = signed'({1'b0, learning_rate});
    assign rate_prod      = rate_s * err;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            teacher_reg <= teacher;
        end
        if (ctrl.sum_en)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.step_en)
        begin
            step_reg <= rate_prod[RPROD_W-1:LR_W];
        end
    end

    assign sum  = sum_reg;
    assign step = step_reg;

endmodule

>>> rtl/delta_rule_associative_learner_unit.sv
// ============================================================================
// Delta-rule associative learner
// Four cue lanes share one sum, error and step path and update their weights
// once per trial unless the trial's action is frozen.
//
//   Channel   Handshake             Word
//   in        in_valid / in_stall   action, cue_0..cue_3, teacher
//   out       out_valid / out_stall summed_activation, weight_0..weight_3
//   cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// After a trial is accepted it passes through the multiply, sum, step and update
// states in turn, and the result word is registered from the update or hold
// state. One trial is in flight at a time, and a new trial can be accepted while
// the previous result word waits on out_stall. A trial that finishes with an
// older word still stalled waits.
// Reset clears the weights, the learning rate and the initial weights.
// Configuration writes are taken in every cycle.
// ============================================================================
module delta_rule_associative_learner_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              action,
    input  logic signed [drla_pkg::CUE_W-1:0]       cue_0,
    input  logic signed [drla_pkg::CUE_W-1:0]       cue_1,
    input  logic signed [drla_pkg::CUE_W-1:0]       cue_2,
    input  logic signed [drla_pkg::CUE_W-1:0]       cue_3,
    input  logic signed [drla_pkg::CUE_W-1:0]       teacher,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [drla_pkg::W_W-1:0]         summed_activation,
    output logic signed [drla_pkg::W_W-1:0]         weight_0,
    output logic signed [drla_pkg::W_W-1:0]         weight_1,
    output logic signed [drla_pkg::W_W-1:0]         weight_2,
    output logic signed [drla_pkg::W_W-1:0]         weight_3,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [drla_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [drla_pkg::W_W-1:0]                cfg_data
);
    import drla_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;
    logic                     frozen_reg;
    logic                     out_valid_reg;
    logic                     out_free;
    logic                     out_load;
    logic [LR_W-1:0]          learning_rate_reg;
    logic signed [W_W-1:0]    init_weight_reg [NUM_CUES];
    logic signed [W_W-1:0]    summed_reg;
    logic signed [W_W-1:0]    out_weight_reg  [NUM_CUES];
    logic signed [CUE_W-1:0]  cue_in          [NUM_CUES];
    logic signed [PROD_W-1:0] lane_product    [NUM_CUES];
    logic signed [W_W-1:0]    lane_weight     [NUM_CUES];
    logic signed [W_W-1:0]    lane_weight_nx  [NUM_CUES];
    logic signed [W_W-1:0]    merge_sum;
    logic signed [STEP_W-1:0] merge_step;
    lane_ctrl_t               lane_ctrl;
    merge_ctrl_t              merge_ctrl;

    assign cue_in[0] = cue_0;
    assign cue_in[1] = cue_1;
    assign cue_in[2] = cue_2;
    assign cue_in[3] = cue_3;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg <= '0;
            for (int i = 0; i < NUM_CUES; i++)
            begin
                init_weight_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_LEARNING_RATE)
            begin
                learning_rate_reg <= cfg_data[LR_W-1:0];
            end
            else if (cfg_index inside {[REG_INIT_BASE:REG_INIT_LAST]})
            begin
                init_weight_reg[CUE_IDX_W'(cfg_index - REG_INIT_BASE)] <= cfg_data;
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_STEP;
            ST_STEP: state_next = ST_UPD;
            ST_UPD, ST_HOLD:
            begin
                state_next = out_free ? ST_IDLE : ST_HOLD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall           = 1'b1;
        lane_ctrl          = '0;
        merge_ctrl         = '0;
        out_load           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall           = 1'b0;
                lane_ctrl.load     = in_valid;
                lane_ctrl.restore  = in_valid && (action == ACT_RESTORE);
                merge_ctrl.load    = in_valid;
            end
            ST_MUL:  lane_ctrl.mul_en    = 1'b1;
            ST_SUM:  merge_ctrl.sum_en   = 1'b1;
            ST_STEP: merge_ctrl.step_en  = 1'b1;
            ST_UPD:
            begin
                lane_ctrl.upd_en = !frozen_reg;
                out_load         = out_free;
            end
            ST_HOLD: out_load = out_free;
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_ctrl.load)
        begin
            frozen_reg <= (action == ACT_FROZEN);
        end
        if (out_load)
        begin
            summed_reg <= merge_sum;
            for (int i = 0; i < NUM_CUES; i++)
            begin
                out_weight_reg[i] <= lane_weight_nx[i];
            end
        end
    end

    for (genvar g = 0; g < NUM_CUES; g++)
    begin : g_lane
        drla_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (lane_ctrl),
            .cue         (cue_in[g]),
            .init_weight (init_weight_reg[g]),
            .step        (merge_step),
            .product     (lane_product[g]),
            .weight      (lane_weight[g]),
            .weight_next (lane_weight_nx[g])
        );
    end

    drla_merge u_merge (
        .clk           (clk),
        .ctrl          (merge_ctrl),
        .product       (lane_product),
        .teacher       (teacher),
        .learning_rate (learning_rate_reg),
        .sum           (merge_sum),
        .step          (merge_step)
    );

    assign out_valid         = out_valid_reg;
    assign summed_activation = summed_reg;
    assign weight_0          = out_weight_reg[0];
    assign weight_1          = out_weight_reg[1];
    assign weight_2          = out_weight_reg[2];
    assign weight_3          = out_weight_reg[3];

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_MUL))
        else $error("accepted word did not start the multiply step");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_UPD || $past(state_reg) == ST_HOLD))
        else $error("result word loaded outside the update or hold step");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> out_valid_reg)
        else $error("hold step entered with an empty result register");

    a_frozen_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && frozen_reg) |=> $stable(lane_weight[0]))
        else $error("frozen trial changed a weight");

endmodule
